>>> hdl/rtu_pkg.sv
// Shared types, constants and CRC function for the RTU CRC-16 frame sealer/checker.
package rtu_pkg;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [2:0]  MIN_FRAME  = 3'd4;
  localparam logic [2:0]  FCS_BYTES  = 3'd2;

  localparam int MAX_PUSH   = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + MAX_PUSH + 1);

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_MODE            = 2'd0;
  localparam cfg_idx_t REG_STATION_ADDRESS = 2'd1;

  typedef enum logic {
    MODE_SEAL  = 1'b0,
    MODE_CHECK = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_BAD_CRC  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       is_last;
    status_t    status;
  } res_t;

  typedef struct packed {
    logic [1:0]       n;
    res_t [MAX_PUSH-1:0] res;
  } bundle_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/rtu_crc16_frame_seal_check.sv
// Top level of the RTU CRC-16 frame sealer and checker.
// Input channel in_*: one frame byte per item, tdata = data_byte, tlast = end_of_frame.
// Output channel out_*: tdata = byte_out, tlast = is_last, tuser = status.
// Configuration channel cfg_*: index 0 = mode (0 seal, 1 check), index 1 = station address;
// cfg_ready is always high, other indexes are ignored. Writing mode clears the frame state.
// Seal mode: each byte is echoed; the last byte is followed by CRC low and CRC high (tlast).
// Check mode: no result per byte; the last byte yields one verdict with tdata zero,
// tlast high and tuser = ok, too short, wrong address or CRC mismatch.
// A result passes through the input register, then the result queue, before it appears.
// Throughput: one item per cycle while in_tready is high, set by the combinational byte
// CRC update; a sealed frame end adds two output results, drained by the eight-entry
// result queue. in_tready depends only on registered queue occupancy and input stage valid.
// When the receiver stalls the queue fills and in_tready drops once fewer than three
// free entries remain beyond the item in the input register.
// Reset (rst_n low, synchronous) empties the queue, drops any frame in progress and
// restores mode = check and station address = 1.
module rtu_crc16_frame_seal_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] byte_out
  output logic       out_tlast,
  output logic [1:0] out_tuser,  // [1:0] status
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic             acc;
  logic             stg_v;
  logic             room;
  rtu_pkg::bundle_t push;
  rtu_pkg::res_t    head;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign acc       = in_tvalid && in_tready;

  rtu_frame_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .data_byte    (in_tdata),
    .end_of_frame (in_tlast),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (rtu_pkg::cfg_idx_t'(cfg_index)),
    .cfg_data     (cfg_data),
    .stg_v        (stg_v),
    .push         (push)
  );

  rtu_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .rsv       (stg_v),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign out_tdata = head.byte_out;
  assign out_tlast = head.is_last;
  assign out_tuser = 2'(head.status);

endmodule

>>> hdl/rtu_frame_core.sv
// Input register, configuration registers and per-byte frame logic producing result bundles.
module rtu_frame_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          data_byte,
  input  logic                end_of_frame,
  input  logic                cfg_we,
  input  rtu_pkg::cfg_idx_t   cfg_index,
  input  logic [7:0]          cfg_data,
  output logic                stg_v,
  output rtu_pkg::bundle_t    push
);

  logic          stg_v_r;
  logic [7:0]    stg_byte_r;
  logic          stg_eof_r;

  rtu_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]    sta_r, sta_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    tail0_r, tail0_nxt;
  logic [7:0]    tail1_r, tail1_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          aok_r, aok_nxt;

  logic [15:0]   crc_seal;
  logic [15:0]   crc_chk;
  rtu_pkg::status_t st;

  assign stg_v    = stg_v_r;
  assign crc_seal = rtu_pkg::crc16_byte(crc_r, stg_byte_r);
  assign crc_chk  = rtu_pkg::crc16_byte(crc_r, tail0_r);

  always_comb begin
    mode_nxt  = mode_r;
    sta_nxt   = sta_r;
    crc_nxt   = crc_r;
    tail0_nxt = tail0_r;
    tail1_nxt = tail1_r;
    cnt_nxt   = cnt_r;
    aok_nxt   = aok_r;
    st        = rtu_pkg::ST_OK;
    push      = '0;

    if (stg_v_r) begin
      if (mode_r == rtu_pkg::MODE_SEAL) begin
        crc_nxt = crc_seal;
        push.n  = 2'd1;
        push.res[0] = '{byte_out: stg_byte_r, is_last: 1'b0, status: rtu_pkg::ST_OK};
        if (stg_eof_r) begin
          push.n = 2'd3;
          push.res[1] = '{byte_out: crc_seal[7:0], is_last: 1'b0, status: rtu_pkg::ST_OK};
          push.res[2] = '{byte_out: crc_seal[15:8], is_last: 1'b1, status: rtu_pkg::ST_OK};
        end
      end else begin
        if (cnt_r == 3'd0) begin
          aok_nxt = (stg_byte_r == sta_r);
        end
        if (cnt_r >= rtu_pkg::FCS_BYTES) begin
          crc_nxt = crc_chk;
        end
        tail0_nxt = tail1_r;
        tail1_nxt = stg_byte_r;
        if (cnt_r < rtu_pkg::MIN_FRAME) begin
          cnt_nxt = cnt_r + 3'd1;
        end
        if (stg_eof_r) begin
          if (cnt_nxt < rtu_pkg::MIN_FRAME) begin
            st = rtu_pkg::ST_SHORT;
          end else if (!aok_nxt) begin
            st = rtu_pkg::ST_BAD_ADDR;
          end else if (tail0_nxt != crc_nxt[7:0] || tail1_nxt != crc_nxt[15:8]) begin
            st = rtu_pkg::ST_BAD_CRC;
          end
          push.n = 2'd1;
          push.res[0] = '{byte_out: 8'h00, is_last: 1'b1, status: st};
        end
      end
      if (stg_eof_r) begin
        crc_nxt   = rtu_pkg::CRC_PRESET;
        tail0_nxt = '0;
        tail1_nxt = '0;
        cnt_nxt   = '0;
        aok_nxt   = 1'b0;
      end
    end

    if (cfg_we) begin
      unique case (cfg_index)
        rtu_pkg::REG_MODE: begin
          mode_nxt  = rtu_pkg::mode_t'(cfg_data[0]);
          crc_nxt   = rtu_pkg::CRC_PRESET;
          tail0_nxt = '0;
          tail1_nxt = '0;
          cnt_nxt   = '0;
          aok_nxt   = 1'b0;
        end
        rtu_pkg::REG_STATION_ADDRESS: begin
          sta_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      mode_r  <= rtu_pkg::MODE_CHECK;
      sta_r   <= 8'd1;
      crc_r   <= rtu_pkg::CRC_PRESET;
      tail0_r <= '0;
      tail1_r <= '0;
      cnt_r   <= '0;
      aok_r   <= 1'b0;
    end else begin
      stg_v_r <= acc;
      mode_r  <= mode_nxt;
      sta_r   <= sta_nxt;
      crc_r   <= crc_nxt;
      tail0_r <= tail0_nxt;
      tail1_r <= tail1_nxt;
      cnt_r   <= cnt_nxt;
      aok_r   <= aok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      stg_byte_r <= data_byte;
      stg_eof_r  <= end_of_frame;
    end
  end

endmodule

>>> hdl/rtu_res_fifo.sv
// Result queue taking up to three results a cycle and presenting one result a cycle while the receiver is ready.
module rtu_res_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  rtu_pkg::bundle_t push,
  input  logic             rsv,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output rtu_pkg::res_t    out_res
);

  rtu_pkg::res_t mem_r [rtu_pkg::FIFO_DEPTH];

  logic [rtu_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rtu_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rtu_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic                        pop;
  logic [rtu_pkg::FIFO_CW-1:0] pending;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign pending   = cnt_r + (rsv ? rtu_pkg::FIFO_CW'(rtu_pkg::MAX_PUSH) : '0);
  assign room      = (pending <= rtu_pkg::FIFO_CW'(rtu_pkg::FIFO_DEPTH - rtu_pkg::MAX_PUSH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + rtu_pkg::FIFO_AW'(push.n);
    rd_ptr_nxt = rd_ptr_r + rtu_pkg::FIFO_AW'(pop);
    cnt_nxt    = cnt_r + rtu_pkg::FIFO_CW'(push.n) - rtu_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < rtu_pkg::MAX_PUSH; k++) begin
      if (2'(k) < push.n) begin
        mem_r[wr_ptr_r + rtu_pkg::FIFO_AW'(k)] <= push.res[k];
      end
    end
  end

endmodule

>>> hdl/rtu_chk.sv
// Port-level checker for the RTU CRC-16 frame sealer and checker, with its bind.
module rtu_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd0 |-> out_tlast)
    else $error("non-ok status on a result that is not last");

  a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd0 |-> out_tdata == 8'h00)
    else $error("verdict carries a non-zero byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind rtu_crc16_frame_seal_check rtu_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
